### hw/rtl/hpa_pkg.sv
// Package with the shared types and constants of the binary16 adder.
`timescale 1ns / 1ps
package hpa_pkg;
  localparam logic [15:0] QNAN_CODE = 16'h7e00;
  localparam logic [15:0] SIGN_BIT  = 16'h8000;

  typedef struct packed {
    logic        special;
    logic [15:0] special_val;
    logic        sign;
    logic [4:0]  exp;
    logic [10:0] big_sig;
    logic [10:0] small_sig;
    logic        sub;
  } align_t;

  typedef struct packed {
    logic        special;
    logic [15:0] special_val;
    logic        sign;
    logic [4:0]  exp;
    logic [11:0] sum;
  } norm_t;
endpackage

### hw/rtl/hpa_norm.sv
// Normalisation stage: leading-zero count, exponent adjust and packing.
`timescale 1ns / 1ps
module hpa_norm (
  input  hpa_pkg::norm_t n,
  output logic [15:0]    res
);
  logic [3:0] lz;
  logic [6:0] e;
  logic [10:0] m;
  always_comb begin
    lz = 4'd11;
    for (int i = 0; i <= 10; i++) begin
      if (n.sum[i]) begin
        lz = 4'(10 - i);
      end
    end
    if (n.sum[11]) begin
      e = {2'b00, n.exp} + 7'd1;
      m = n.sum[11:1];
    end else begin
      e = {2'b00, n.exp} - {3'b000, lz};
      m = n.sum[10:0] << lz;
    end
    if (n.special) begin
      res = n.special_val;
    end else if (n.sum == 12'd0) begin
      res = 16'h0000;
    end else if (!e[6] && e >= 7'd31) begin
      res = {n.sign, 5'h1f, 10'h000};
    end else if (e[6] || e == 7'd0) begin
      res = {n.sign, 15'h0000};
    end else begin
      res = {n.sign, e[4:0], m[9:0]};
    end
  end
endmodule

### hw/rtl/half_precision_adder.sv
// Top level of the pipelined binary16 adder.
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (low bit first)
// in_     | in  | operand_a[15:0], operand_b[31:16]
// out_    | out | sum_value[15:0]
// One request is taken every cycle while the pipeline is not held by a stall.
// The result passes through the input, align, add and normalise registers.
// Reset clears the valid bits.
// A stall at the output holds each stage whose successor is full, while empty
// stages still fill.
module half_precision_adder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operand_a, operand_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // sum_value
);
  logic [3:0] v_r;
  logic [3:0] adv;
  logic [31:0] op_r;
  hpa_pkg::align_t al_nxt, al_r;
  hpa_pkg::norm_t ad_nxt, ad_r;
  logic [15:0] res_nxt, res_r;

  always_comb begin
    adv[3] = !v_r[3] || out_tready;
    adv[2] = !v_r[2] || adv[3];
    adv[1] = !v_r[1] || adv[2];
    adv[0] = !v_r[0] || adv[1];
  end
  assign in_tready  = adv[0];
  assign out_tvalid = v_r[3];
  assign out_tdata  = res_r;

  logic [15:0] a, b;
  logic [4:0] ea, eb, d;
  logic [10:0] ma, mb;
  logic a_big;
  always_comb begin
    a = op_r[15:0];
    b = op_r[31:16];
    ea = a[14:10];
    eb = b[14:10];
    ma = {1'b1, a[9:0]};
    mb = {1'b1, b[9:0]};
    a_big = (ea > eb) || (ea == eb && ma >= mb);
    al_nxt.special = 1'b1;
    al_nxt.special_val = 16'h0000;
    if (ea == 5'd0 && eb == 5'd0) begin
      al_nxt.special_val = 16'h0000;
    end else if ((a ^ b) == hpa_pkg::SIGN_BIT) begin
      al_nxt.special_val = 16'h0000;
    end else if (ea == 5'd0) begin
      al_nxt.special_val = b;
    end else if (eb == 5'd0) begin
      al_nxt.special_val = a;
    end else if (ea == 5'd31 || eb == 5'd31) begin
      al_nxt.special_val = hpa_pkg::QNAN_CODE;
    end else begin
      al_nxt.special = 1'b0;
    end
    al_nxt.sub = a[15] ^ b[15];
    if (a_big) begin
      d = ea - eb;
      al_nxt.sign = a[15];
      al_nxt.exp = ea;
      al_nxt.big_sig = ma;
      al_nxt.small_sig = (d >= 5'd12) ? 11'd0 : mb >> d;
    end else begin
      d = eb - ea;
      al_nxt.sign = b[15];
      al_nxt.exp = eb;
      al_nxt.big_sig = mb;
      al_nxt.small_sig = (d >= 5'd12) ? 11'd0 : ma >> d;
    end
  end

  always_comb begin
    ad_nxt.special = al_r.special;
    ad_nxt.special_val = al_r.special_val;
    ad_nxt.sign = al_r.sign;
    ad_nxt.exp = al_r.exp;
    if (al_r.sub) begin
      ad_nxt.sum = {1'b0, al_r.big_sig} - {1'b0, al_r.small_sig};
    end else begin
      ad_nxt.sum = {1'b0, al_r.big_sig} + {1'b0, al_r.small_sig};
    end
  end

  hpa_norm u_norm (
    .n   (ad_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 4'd0;
    end else begin
      if (adv[0]) v_r[0] <= in_tvalid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
      if (adv[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) op_r <= in_tdata;
    if (adv[1]) al_r <= al_nxt;
    if (adv[2]) ad_r <= ad_nxt;
    if (adv[3]) res_r <= res_nxt;
  end
endmodule
